### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the timer unit RTL; empty when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MCST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MCST_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MCST_ASSERT(lbl, clk, rst_n, prop, msg)
`define MCST_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/mcst_pkg.sv
// ----------------------------------------------------------------------------
// Timer unit package
// Types, field widths and constants shared by the timer unit modules.
// ----------------------------------------------------------------------------
package mcst_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int CH_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam int FUNC_W   = 2;
    localparam int IN_CH_W  = 8;
    localparam int MS_W     = 16;
    localparam int RUNS_W   = 16;
    localparam int RATE_W   = 14;
    localparam int TICKS_W  = 20;
    localparam int OUT_CH_W = 6;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    localparam logic [RATE_W-1:0]  RATE_RESET   = 14'd1000;
    localparam logic [RUNS_W-1:0]  RUNS_FOREVER = 16'hFFFF;
    localparam logic [RUNS_W-1:0]  RUNS_STOPPED = 16'h0000;
    localparam logic [TICKS_W-1:0] TICKS_MAX    = 20'hFFFFF;

    // floor(p / 1000) = floor((p >> 3) / 125), the latter by reciprocal multiply
    localparam int    MS_PER_SECOND = 1000;
    localparam int    PRESHIFT      = 3;
    localparam int    DIVISOR       = MS_PER_SECOND >> PRESHIFT;
    localparam int    PROD_W        = MS_W + RATE_W;
    localparam int    DIVN_W        = PROD_W - PRESHIFT;
    localparam int    RECIP_SHIFT   = DIVN_W + 7;
    localparam int    RECIP_W       = 28;
    localparam longint RECIP_L      = ((longint'(1) <<< RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int    RPROD_W       = DIVN_W + RECIP_W;
    localparam int    QUOT_W        = RPROD_W - RECIP_SHIFT;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_STOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [CH_W-1:0]    ch;
        logic [TICKS_W-1:0] ticks;
        logic [RUNS_W-1:0]  runs;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } t_walk_state;

endpackage

### hw/rtl/mcst_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short queue of classified commands between the front end and the channel
// walker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcst_fifo
    import mcst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `MCST_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `MCST_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_count == '0) |-> (r_wr_ptr == r_rd_ptr), "queue pointers disagree when empty")
    `MCST_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")

endmodule

### hw/rtl/mcst_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts input transactions, classifies them, converts the period from
// milliseconds to ticks and pushes kept commands into the queue.
// ----------------------------------------------------------------------------
module mcst_front
    import mcst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RATE_W-1:0]   i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [IN_CH_W-1:0]  i_channel,
    input  logic [MS_W-1:0]     i_period_ms,
    input  logic [RUNS_W-1:0]   i_run_count,
    output logic                o_push,
    output t_cmd                o_cmd,
    input  logic                i_q_full
);

    logic [RATE_W-1:0]  r_rate;

    logic               r_a_valid;
    logic               r_a_keep;
    t_op                r_a_op;
    logic [CH_W-1:0]    r_a_ch;
    logic [RUNS_W-1:0]  r_a_runs;
    logic [PROD_W-1:0]  r_a_prod;

    logic               r_b_valid;
    logic               r_b_keep;
    t_op                r_b_op;
    logic [CH_W-1:0]    r_b_ch;
    logic [RUNS_W-1:0]  r_b_runs;
    logic [QUOT_W-1:0]  r_b_quot;

    logic               accept;
    logic               adv_a;
    logic               adv_b;
    logic               in_range;
    logic               a_keep;
    t_op                a_op;
    logic [RPROD_W-1:0] recip_prod;

    assign adv_b      = !r_b_valid || !r_b_keep || !i_q_full;
    assign adv_a      = !r_a_valid || adv_b;
    assign o_in_ready = adv_a;
    assign accept     = i_in_valid && o_in_ready;
    assign in_range   = (i_channel < IN_CH_W'(NUM_TIMERS));

    // drop unused codes, and start or stop commands on out-of-range channels, here
    always_comb begin
        a_op   = OP_TICK;
        a_keep = 1'b0;
        unique case (i_func)
            FUNC_TICK: begin
                a_op   = OP_TICK;
                a_keep = 1'b1;
            end
            FUNC_START: begin
                a_op   = OP_START;
                a_keep = in_range;
            end
            FUNC_STOP: begin
                a_op   = OP_STOP;
                a_keep = in_range;
            end
            FUNC_NONE: begin
                a_keep = 1'b0;
            end
        endcase
    end

    assign recip_prod = RPROD_W'(r_a_prod[PROD_W-1:PRESHIFT]) * RPROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate    <= RATE_RESET;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (adv_a) begin
                r_a_valid <= accept;
            end
            if (adv_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && accept) begin
            r_a_keep <= a_keep;
            r_a_op   <= a_op;
            r_a_ch   <= CH_W'(i_channel);
            r_a_runs <= i_run_count;
            r_a_prod <= PROD_W'(i_period_ms) * PROD_W'(r_rate);
        end
        if (adv_b && r_a_valid) begin
            r_b_keep <= r_a_keep;
            r_b_op   <= r_a_op;
            r_b_ch   <= r_a_ch;
            r_b_runs <= r_a_runs;
            r_b_quot <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    assign o_push   = r_b_valid && r_b_keep && !i_q_full;
    assign o_cmd.op = r_b_op;
    assign o_cmd.ch = r_b_ch;
    // saturate long periods
    assign o_cmd.ticks = (r_b_quot > QUOT_W'(TICKS_MAX)) ? TICKS_MAX : r_b_quot[TICKS_W-1:0];
    assign o_cmd.runs  = r_b_runs;

endmodule

### hw/rtl/mcst_back.sv
// ----------------------------------------------------------------------------
// Channel walker
// Holds the per-channel state, applies start and stop commands and walks
// all channels on a tick, emitting one result per fired channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcst_back
    import mcst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OUT_CH_W-1:0] o_fired_channel,
    output logic [RUNS_W-1:0]   o_runs_left,
    output logic                o_last
);

    logic [TICKS_W-1:0] r_rem_mem  [NUM_TIMERS];
    logic [TICKS_W-1:0] r_rel_mem  [NUM_TIMERS];
    logic [RUNS_W-1:0]  r_runs_mem [NUM_TIMERS];
    logic               r_vld      [NUM_TIMERS];

    logic [TICKS_W-1:0] r_rd_rem;
    logic [TICKS_W-1:0] r_rd_rel;
    logic [RUNS_W-1:0]  r_rd_runs;
    logic               r_rd_vld;

    t_walk_state        r_state;
    t_walk_state        n_state;
    logic [CH_W-1:0]    r_idx;
    logic [CH_W-1:0]    n_idx;
    logic               r_pend_valid;
    logic               n_pend_valid;
    logic [CH_W-1:0]    r_pend_ch;
    logic [CH_W-1:0]    n_pend_ch;
    logic [RUNS_W-1:0]  r_pend_runs;
    logic [RUNS_W-1:0]  n_pend_runs;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [CH_W-1:0]    r_out_ch;
    logic [CH_W-1:0]    n_out_ch;
    logic [RUNS_W-1:0]  r_out_runs;
    logic [RUNS_W-1:0]  n_out_runs;
    logic               r_out_last;
    logic               n_out_last;

    logic [CH_W-1:0]    rd_addr;
    logic [CH_W-1:0]    wr_addr;
    logic               rem_we;
    logic [TICKS_W-1:0] rem_wdata;
    logic               rel_we;
    logic               runs_we;
    logic [RUNS_W-1:0]  runs_wdata;

    logic               out_free;
    logic [RUNS_W-1:0]  d_runs;
    logic               ch_active;
    logic               ch_fire;
    logic [RUNS_W-1:0]  runs_next;
    logic               is_last_ch;
    logic               stall;

    assign out_free   = !r_out_valid || i_out_ready;
    assign d_runs     = r_rd_vld ? r_rd_runs : RUNS_STOPPED;
    assign ch_active  = (d_runs != RUNS_STOPPED);
    assign ch_fire    = ch_active && (r_rd_rem == '0);
    assign runs_next  = (d_runs == RUNS_FOREVER) ? d_runs : d_runs - 1'b1;
    assign is_last_ch = (r_idx == CH_W'(NUM_TIMERS - 1));
    // a second firing needs the held result moved out first
    assign stall      = ch_fire && r_pend_valid && !out_free;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_ch    = r_pend_ch;
        n_pend_runs  = r_pend_runs;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_ch     = r_out_ch;
        n_out_runs   = r_out_runs;
        n_out_last   = r_out_last;
        o_cmd_pop    = 1'b0;
        rd_addr      = r_idx;
        wr_addr      = r_idx;
        rem_we       = 1'b0;
        rem_wdata    = r_rd_rel;
        rel_we       = 1'b0;
        runs_we      = 1'b0;
        runs_wdata   = runs_next;
        unique case (r_state)
            S_IDLE: begin
                rd_addr = '0;
                wr_addr = i_cmd.ch;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.op)
                        OP_START: begin
                            rem_we     = 1'b1;
                            rem_wdata  = i_cmd.ticks;
                            rel_we     = 1'b1;
                            runs_we    = 1'b1;
                            runs_wdata = i_cmd.runs;
                        end
                        OP_STOP: begin
                            runs_we    = 1'b1;
                            runs_wdata = RUNS_STOPPED;
                        end
                        OP_TICK: begin
                            n_idx   = '0;
                            n_state = S_WALK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (!stall) begin
                    if (ch_fire) begin
                        rem_we       = 1'b1;
                        rem_wdata    = r_rd_rel;
                        runs_we      = 1'b1;
                        runs_wdata   = runs_next;
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_ch    = r_pend_ch;
                            n_out_runs  = r_pend_runs;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_ch    = r_idx;
                        n_pend_runs  = runs_next;
                    end else if (ch_active) begin
                        rem_we    = 1'b1;
                        rem_wdata = r_rd_rem - 1'b1;
                    end
                    if (is_last_ch) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        rd_addr = r_idx + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_ch     = r_pend_ch;
                    n_out_runs   = r_pend_runs;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (runs_we) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_ch   <= n_pend_ch;
        r_pend_runs <= n_pend_runs;
        r_out_ch    <= n_out_ch;
        r_out_runs  <= n_out_runs;
        r_out_last  <= n_out_last;
    end

    // channel state memories, registered read
    always_ff @(posedge i_clk) begin
        if (rem_we) begin
            r_rem_mem[wr_addr] <= rem_wdata;
        end
        if (rel_we) begin
            r_rel_mem[wr_addr] <= i_cmd.ticks;
        end
        if (runs_we) begin
            r_runs_mem[wr_addr] <= runs_wdata;
        end
        r_rd_rem  <= r_rem_mem[rd_addr];
        r_rd_rel  <= r_rel_mem[rd_addr];
        r_rd_runs <= r_runs_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    assign o_out_valid     = r_out_valid;
    assign o_fired_channel = OUT_CH_W'(r_out_ch);
    assign o_runs_left     = r_out_runs;
    assign o_last          = r_out_last;

    `MCST_ASSERT(a_idle_no_pend, i_clk, i_rst_n, (r_state == S_IDLE) |-> !r_pend_valid, "held result left over after a tick")
    `MCST_ASSERT(a_out_ch_range, i_clk, i_rst_n, r_out_valid |-> (r_out_ch <= CH_W'(NUM_TIMERS - 1)), "fired channel out of range")
    `MCST_ASSERT(a_flush_entry, i_clk, i_rst_n, (r_state == S_FLUSH) |-> ($past(r_state) == S_WALK || $past(r_state) == S_FLUSH), "flush entered without a walk")

endmodule

### hw/rtl/multi_channel_soft_timer_unit.sv
// ----------------------------------------------------------------------------
// Multi-channel soft timer unit
// Bank of timer channels started, stopped and advanced by input
// transactions; each tick reports the channels that fire.
// ----------------------------------------------------------------------------
// A start or stop transaction passes front-end stages A and B and the queue
// before the channel walker applies it in its idle state; the front end
// converts the period to ticks by two pipelined multiplies. A tick is a pop,
// a walk over the channels one at a time, as set by the single read port of
// the channel state memories, and a flush step that releases the final result;
// the walker holds while a firing or the final result waits on a busy output.
// A four-entry queue lets the front end keep taking transactions while the
// walker is busy. Reset stops every channel at once through per-channel
// valid bits; there is no clearing pass.
module multi_channel_soft_timer_unit
    import mcst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RATE_W-1:0]   i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [IN_CH_W-1:0]  i_channel,
    input  logic [MS_W-1:0]     i_period_ms,
    input  logic [RUNS_W-1:0]   i_run_count,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [OUT_CH_W-1:0] o_fired_channel,
    output logic [RUNS_W-1:0]   o_runs_left,
    output logic                o_last
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    mcst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_channel   (i_channel),
        .i_period_ms (i_period_ms),
        .i_run_count (i_run_count),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_q_full    (q_full)
    );

    mcst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    mcst_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (q_valid),
        .i_cmd           (q_cmd),
        .o_cmd_pop       (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_fired_channel (o_fired_channel),
        .o_runs_left     (o_runs_left),
        .o_last          (o_last)
    );

endmodule
